// ----- src/routing_init_sublayer_fsm_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the routing init sublayer FSM unit
// Short forms for clocked concurrent assertions, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef ROUTING_INIT_SUBLAYER_FSM_UNIT_ASSERT_SVH
`define ROUTING_INIT_SUBLAYER_FSM_UNIT_ASSERT_SVH

// Checked on every rising edge, switched off while reset is asserted.
`define RIFSM_ASSERT(lbl, clk_e, rst_e, prop, msg) \
    lbl: assert property (@(posedge clk_e) disable iff (!rst_e) prop) \
        else $error(msg);

// Checked on every rising edge, reset included.
`define RIFSM_ASSERT_NORST(lbl, clk_e, prop, msg) \
    lbl: assert property (@(posedge clk_e) prop) else $error(msg);

`endif

// ----- src/rifsm_pkg.sv -----
// ----------------------------------------------------------------------------
// rifsm_pkg
// Types, codes and the transition table of the routing init sublayer FSM.
// ----------------------------------------------------------------------------
package rifsm_pkg;

    // circuit states
    localparam logic [2:0] ST_RUN      = 3'd0;
    localparam logic [2:0] ST_REJECTED = 3'd1;
    localparam logic [2:0] ST_DL_START = 3'd2;
    localparam logic [2:0] ST_INIT     = 3'd3;
    localparam logic [2:0] ST_VERIFY   = 3'd4;
    localparam logic [2:0] ST_COMPLETE = 3'd5;
    localparam logic [2:0] ST_OFF      = 3'd6;
    localparam logic [2:0] ST_HALT     = 3'd7;

    // item operation codes
    localparam logic [3:0] OP_TICK        = 4'd0;
    localparam logic [3:0] OP_INIT_MSG    = 4'd1;
    localparam logic [3:0] OP_VERIFY_MSG  = 4'd2;
    localparam logic [3:0] OP_START_DONE  = 4'd3;
    localparam logic [3:0] OP_START_ERR   = 4'd4;
    localparam logic [3:0] OP_OPER_ON     = 4'd5;
    localparam logic [3:0] OP_OPER_OFF    = 4'd6;
    localparam logic [3:0] OP_INVALID     = 4'd7;
    localparam logic [3:0] OP_REJECT_DONE = 4'd8;
    localparam logic [3:0] OP_DOWN_DONE   = 4'd9;
    localparam logic [3:0] OP_UP_DONE     = 4'd10;
    localparam logic [3:0] OP_LINE_DOWN   = 4'd11;

    // table events (rows)
    localparam logic [3:0] EV_INIT_VRFY   = 4'd0;
    localparam logic [3:0] EV_INIT_NOVRFY = 4'd1;
    localparam logic [3:0] EV_VERIFY      = 4'd2;
    localparam logic [3:0] EV_TIMEOUT     = 4'd3;
    localparam logic [3:0] EV_START_DONE  = 4'd4;
    localparam logic [3:0] EV_START_ERR   = 4'd5;
    localparam logic [3:0] EV_OPER_ON     = 4'd6;
    localparam logic [3:0] EV_OPER_OFF    = 4'd7;
    localparam logic [3:0] EV_INVALID     = 4'd8;
    localparam logic [3:0] EV_REJECT_DONE = 4'd9;
    localparam logic [3:0] EV_DOWN_DONE   = 4'd10;
    localparam logic [3:0] EV_UP_DONE     = 4'd11;

    // table actions
    localparam logic [2:0] ACT_NONE   = 3'd0;
    localparam logic [2:0] ACT_REINIT = 3'd1;
    localparam logic [2:0] ACT_STOP   = 3'd2;
    localparam logic [2:0] ACT_INIT   = 3'd3;
    localparam logic [2:0] ACT_VERIFY = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_OWN_AREA     = 2'd0;
    localparam logic [1:0] CFG_OWN_LEVEL    = 2'd1;
    localparam logic [1:0] CFG_MAX_NODE     = 2'd2;
    localparam logic [1:0] CFG_RECALL_TICKS = 2'd3;

    localparam logic [1:0] LEVEL_1      = 2'd1;
    localparam logic [1:0] LEVEL_2      = 2'd2;
    localparam logic [1:0] NODE_TYPE_L1 = 2'd2;

    // entry = {action, next state}, octal digits read as action then state
    localparam logic [5:0] TRANS_TABLE [0:11][0:7] = '{
        '{6'o01, 6'o01, 6'o02, 6'o44, 6'o12, 6'o12, 6'o06, 6'o07},
        '{6'o01, 6'o01, 6'o02, 6'o04, 6'o12, 6'o12, 6'o06, 6'o07},
        '{6'o01, 6'o01, 6'o02, 6'o12, 6'o05, 6'o12, 6'o06, 6'o07},
        '{6'o00, 6'o01, 6'o12, 6'o12, 6'o12, 6'o05, 6'o06, 6'o07},
        '{6'o01, 6'o01, 6'o33, 6'o12, 6'o12, 6'o12, 6'o06, 6'o07},
        '{6'o01, 6'o01, 6'o12, 6'o12, 6'o12, 6'o12, 6'o06, 6'o07},
        '{6'o00, 6'o01, 6'o02, 6'o03, 6'o04, 6'o05, 6'o01, 6'o12},
        '{6'o26, 6'o06, 6'o27, 6'o27, 6'o27, 6'o27, 6'o06, 6'o07},
        '{6'o01, 6'o01, 6'o02, 6'o12, 6'o12, 6'o12, 6'o06, 6'o07},
        '{6'o01, 6'o01, 6'o02, 6'o03, 6'o04, 6'o12, 6'o06, 6'o07},
        '{6'o00, 6'o12, 6'o02, 6'o03, 6'o04, 6'o05, 6'o07, 6'o07},
        '{6'o00, 6'o01, 6'o02, 6'o03, 6'o04, 6'o00, 6'o06, 6'o07}
    };

    typedef struct packed {
        logic [5:0]  own_area;
        logic [1:0]  own_level;
        logic [9:0]  max_node;
        logic [15:0] recall_ticks;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  circuit_state;
        logic        recall_active;
        logic [15:0] recall_count;
    } ctl_state_t;

    typedef struct packed {
        logic [3:0]  operation;
        logic [5:0]  src_area;
        logic [9:0]  src_node;
        logic [1:0]  node_type;
        logic        verify_requested;
        logic        version_ok;
        logic [15:0] hello_timer;
    } item_t;

    typedef struct packed {
        logic [2:0]  new_state;
        logic        start_line;
        logic        stop_line;
        logic        send_init;
        logic        send_verify;
        logic        circuit_up;
        logic        circuit_down;
        logic        adjacency_init;
        logic [15:0] adj_address;
        logic [1:0]  adj_type;
        logic [15:0] adj_hello;
        logic        last;
    } res_t;

endpackage

// ----- src/rifsm_in_if.sv -----
// ----------------------------------------------------------------------------
// rifsm_in_if
// Event item channel: valid/ready handshake plus the event payload.
// ----------------------------------------------------------------------------
interface rifsm_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  operation;
    logic [5:0]  src_area;
    logic [9:0]  src_node;
    logic [1:0]  node_type;
    logic        verify_requested;
    logic        version_ok;
    logic [15:0] hello_timer;

    modport source (
        output valid, operation, src_area, src_node, node_type,
               verify_requested, version_ok, hello_timer,
        input  ready
    );

    modport sink (
        input  valid, operation, src_area, src_node, node_type,
               verify_requested, version_ok, hello_timer,
        output ready
    );
endinterface

// ----- src/rifsm_out_if.sv -----
// ----------------------------------------------------------------------------
// rifsm_out_if
// Result item channel: valid/ready handshake plus the result payload.
// ----------------------------------------------------------------------------
interface rifsm_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  new_state;
    logic        start_line;
    logic        stop_line;
    logic        send_init;
    logic        send_verify;
    logic        circuit_up;
    logic        circuit_down;
    logic        adjacency_init;
    logic [15:0] adj_address;
    logic [1:0]  adj_type;
    logic [15:0] adj_hello;
    logic        last;

    modport source (
        output valid, new_state, start_line, stop_line, send_init, send_verify,
               circuit_up, circuit_down, adjacency_init, adj_address, adj_type,
               adj_hello, last,
        input  ready
    );

    modport sink (
        input  valid, new_state, start_line, stop_line, send_init, send_verify,
               circuit_up, circuit_down, adjacency_init, adj_address, adj_type,
               adj_hello, last,
        output ready
    );
endinterface

// ----- src/rifsm_eval.sv -----
// ----------------------------------------------------------------------------
// rifsm_eval
// Combinational event evaluation: one item against the current state.
// ----------------------------------------------------------------------------
module rifsm_eval (
    input  rifsm_pkg::cfg_t       cfg,
    input  rifsm_pkg::ctl_state_t cur,
    input  rifsm_pkg::item_t      item,
    output rifsm_pkg::ctl_state_t nxt,
    output rifsm_pkg::res_t       res0,
    output rifsm_pkg::res_t       res1,
    output logic                  two_results
);

    typedef struct packed {
        rifsm_pkg::ctl_state_t st;
        rifsm_pkg::res_t       r;
    } ev_out_t;

    function automatic ev_out_t apply_event(
        input logic [3:0]            ev,
        input rifsm_pkg::ctl_state_t st,
        input logic [15:0]           ticks
    );
        ev_out_t    o;
        logic [5:0] e;
        logic [2:0] ns;
        logic [2:0] act;
        e   = rifsm_pkg::TRANS_TABLE[ev][st.circuit_state];
        ns  = e[2:0];
        act = e[5:3];
        o.st = st;
        o.st.circuit_state = ns;
        o.r = '0;
        o.r.new_state = ns;
        case (act)
            rifsm_pkg::ACT_REINIT:
            begin
                // skipped while the recall timer runs
                if (!st.recall_active)
                begin
                    o.r.start_line     = 1'b1;
                    o.st.recall_active = 1'b1;
                    o.st.recall_count  = ticks;
                end
            end
            rifsm_pkg::ACT_STOP:   o.r.stop_line   = 1'b1;
            rifsm_pkg::ACT_INIT:   o.r.send_init   = 1'b1;
            rifsm_pkg::ACT_VERIFY: o.r.send_verify = 1'b1;
            default: ;
        endcase
        if (ns != st.circuit_state)
        begin
            if (ns == rifsm_pkg::ST_COMPLETE)
                o.r.circuit_up = 1'b1;
            else if (ns == rifsm_pkg::ST_REJECTED || ns == rifsm_pkg::ST_OFF)
                o.r.circuit_down = 1'b1;
        end
        return o;
    endfunction

    logic                  init_valid;
    logic [3:0]            ev_sel;
    rifsm_pkg::ctl_state_t tick_st;
    ev_out_t               a_main;
    ev_out_t               a_tick;
    ev_out_t               a_off;
    ev_out_t               a_on;

    always_comb
    begin
        init_valid = (item.src_node <= cfg.max_node) && (item.version_ok == 1'b1);
        if (cfg.own_level == rifsm_pkg::LEVEL_1 && item.src_area != cfg.own_area)
            init_valid = 1'b0;
        if (cfg.own_level == rifsm_pkg::LEVEL_2 && item.node_type == rifsm_pkg::NODE_TYPE_L1
            && item.src_area != cfg.own_area)
            init_valid = 1'b0;
    end

    always_comb
    begin
        case (item.operation)
            rifsm_pkg::OP_INIT_MSG:
                ev_sel = !init_valid ? rifsm_pkg::EV_INVALID :
                         (item.verify_requested ? rifsm_pkg::EV_INIT_VRFY
                                                : rifsm_pkg::EV_INIT_NOVRFY);
            rifsm_pkg::OP_VERIFY_MSG:  ev_sel = rifsm_pkg::EV_VERIFY;
            rifsm_pkg::OP_START_DONE:  ev_sel = rifsm_pkg::EV_START_DONE;
            rifsm_pkg::OP_START_ERR:   ev_sel = rifsm_pkg::EV_START_ERR;
            rifsm_pkg::OP_OPER_ON:     ev_sel = rifsm_pkg::EV_OPER_ON;
            rifsm_pkg::OP_OPER_OFF:    ev_sel = rifsm_pkg::EV_OPER_OFF;
            rifsm_pkg::OP_REJECT_DONE: ev_sel = rifsm_pkg::EV_REJECT_DONE;
            rifsm_pkg::OP_DOWN_DONE:   ev_sel = rifsm_pkg::EV_DOWN_DONE;
            rifsm_pkg::OP_UP_DONE:     ev_sel = rifsm_pkg::EV_UP_DONE;
            default:                   ev_sel = rifsm_pkg::EV_INVALID;
        endcase
    end

    // timer stopped first, so the timeout's reinit restarts it
    always_comb
    begin
        tick_st = cur;
        tick_st.recall_active = 1'b0;
        tick_st.recall_count  = '0;
    end

    assign a_main = apply_event(ev_sel, cur, cfg.recall_ticks);
    assign a_tick = apply_event(rifsm_pkg::EV_TIMEOUT, tick_st, cfg.recall_ticks);
    assign a_off  = apply_event(rifsm_pkg::EV_OPER_OFF, cur, cfg.recall_ticks);
    assign a_on   = apply_event(rifsm_pkg::EV_OPER_ON, a_off.st, cfg.recall_ticks);

    always_comb
    begin
        nxt  = cur;
        res0 = '0;
        res0.new_state = cur.circuit_state;
        res0.last = 1'b1;
        res1 = '0;
        two_results = 1'b0;
        case (item.operation)
            rifsm_pkg::OP_TICK:
            begin
                if (cur.recall_active)
                begin
                    if (cur.recall_count <= 16'd1)
                    begin
                        if (cur.circuit_state != rifsm_pkg::ST_RUN)
                        begin
                            nxt  = a_tick.st;
                            res0 = a_tick.r;
                            res0.last = 1'b1;
                        end
                        else
                        begin
                            nxt = tick_st;
                        end
                    end
                    else
                    begin
                        nxt.recall_count = cur.recall_count - 16'd1;
                    end
                end
            end
            rifsm_pkg::OP_INIT_MSG:
            begin
                nxt  = a_main.st;
                res0 = a_main.r;
                res0.last = 1'b1;
                if (init_valid)
                begin
                    res0.adjacency_init = 1'b1;
                    res0.adj_address    = {item.src_area, item.src_node};
                    res0.adj_type       = item.node_type;
                    res0.adj_hello      = item.hello_timer;
                end
            end
            rifsm_pkg::OP_VERIFY_MSG, rifsm_pkg::OP_START_DONE, rifsm_pkg::OP_START_ERR,
            rifsm_pkg::OP_OPER_ON, rifsm_pkg::OP_OPER_OFF, rifsm_pkg::OP_INVALID,
            rifsm_pkg::OP_REJECT_DONE, rifsm_pkg::OP_DOWN_DONE, rifsm_pkg::OP_UP_DONE:
            begin
                nxt  = a_main.st;
                res0 = a_main.r;
                res0.last = 1'b1;
            end
            rifsm_pkg::OP_LINE_DOWN:
            begin
                nxt  = a_on.st;
                res0 = a_off.r;
                res0.last = 1'b0;
                res1 = a_on.r;
                res1.last = 1'b1;
                two_results = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

// ----- src/rifsm_res_fifo.sv -----
// ----------------------------------------------------------------------------
// rifsm_res_fifo
// Small result queue; takes one or two results per cycle, gives one.
// ----------------------------------------------------------------------------
module rifsm_res_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  logic            push_two,
    input  rifsm_pkg::res_t din0,
    input  rifsm_pkg::res_t din1,
    output logic            room,
    input  logic            pop,
    output logic            head_valid,
    output rifsm_pkg::res_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    rifsm_pkg::res_t   entries_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign room       = count_reg <= CNT_W'(DEPTH - 2);
    assign head_valid = count_reg != '0;
    assign head       = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        if (push)
            wr_ptr_next = push_two ? ptr_inc(ptr_inc(wr_ptr_reg)) : ptr_inc(wr_ptr_reg);
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'({push & push_two, push & ~push_two})
                      - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= din0;
            if (push_two)
                entries_reg[ptr_inc(wr_ptr_reg)] <= din1;
        end
    end

endmodule

// ----- src/routing_init_sublayer_fsm_unit.sv -----
// ----------------------------------------------------------------------------
// routing_init_sublayer_fsm_unit
// Routing-layer initialisation controller for one point-to-point circuit.
// ----------------------------------------------------------------------------
// One event item is taken per cycle whenever the result queue has room for
// two results; each item is evaluated in the cycle it is accepted (table
// lookup, init message checks, recall timer step) and its results enter the
// queue, showing on the result channel from the next cycle on. Most items
// give one result; line down gives two (operator off, then operator on, the
// second marked last), so it holds the result side for both. Without stalls
// or line downs, one item per cycle is sustained, set by the single-result port.
// Configuration is written through cfg_we/cfg_index/cfg_data, taking effect
// on the next item; write only while the block is idle.
module routing_init_sublayer_fsm_unit #(
    parameter int RES_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    rifsm_in_if.sink    evt,
    rifsm_out_if.source res
);

    // register reset values
    localparam logic [5:0]  OWN_AREA_RST     = 6'd1;
    localparam logic [1:0]  OWN_LEVEL_RST    = 2'd2;
    localparam logic [9:0]  MAX_NODE_RST     = 10'd1023;
    localparam logic [15:0] RECALL_TICKS_RST = 16'd10;

    rifsm_pkg::cfg_t       cfg_reg;
    rifsm_pkg::ctl_state_t ctl_reg;
    rifsm_pkg::ctl_state_t ctl_next;
    rifsm_pkg::item_t      item;
    rifsm_pkg::res_t       res0;
    rifsm_pkg::res_t       res1;
    rifsm_pkg::res_t       head;
    logic                  two_results;
    logic                  room;
    logic                  accept;
    logic                  head_valid;

    // item gathered from the event channel
    always_comb
    begin
        item.operation        = evt.operation;
        item.src_area         = evt.src_area;
        item.src_node         = evt.src_node;
        item.node_type        = evt.node_type;
        item.verify_requested = evt.verify_requested;
        item.version_ok       = evt.version_ok;
        item.hello_timer      = evt.hello_timer;
    end

    assign evt.ready = room;
    assign accept    = evt.valid && room;

    rifsm_eval u_eval (
        .cfg         (cfg_reg),
        .cur         (ctl_reg),
        .item        (item),
        .nxt         (ctl_next),
        .res0        (res0),
        .res1        (res1),
        .two_results (two_results)
    );

    // circuit state and recall timer move only on an accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg.circuit_state <= rifsm_pkg::ST_OFF;
            ctl_reg.recall_active <= 1'b0;
            ctl_reg.recall_count  <= '0;
        end
        else if (accept)
        begin
            ctl_reg <= ctl_next;
        end
    end

    // configuration registers, bits above each register's width dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_area     <= OWN_AREA_RST;
            cfg_reg.own_level    <= OWN_LEVEL_RST;
            cfg_reg.max_node     <= MAX_NODE_RST;
            cfg_reg.recall_ticks <= RECALL_TICKS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rifsm_pkg::CFG_OWN_AREA:     cfg_reg.own_area     <= cfg_data[5:0];
                rifsm_pkg::CFG_OWN_LEVEL:    cfg_reg.own_level    <= cfg_data[1:0];
                rifsm_pkg::CFG_MAX_NODE:     cfg_reg.max_node     <= cfg_data[9:0];
                rifsm_pkg::CFG_RECALL_TICKS: cfg_reg.recall_ticks <= cfg_data;
                default: ;
            endcase
        end
    end

    // result queue decouples the event side from a stalled result side
    rifsm_res_fifo #(
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_two   (two_results),
        .din0       (res0),
        .din1       (res1),
        .room       (room),
        .pop        (head_valid && res.ready),
        .head_valid (head_valid),
        .head       (head)
    );

    assign res.valid          = head_valid;
    assign res.new_state      = head.new_state;
    assign res.start_line     = head.start_line;
    assign res.stop_line      = head.stop_line;
    assign res.send_init      = head.send_init;
    assign res.send_verify    = head.send_verify;
    assign res.circuit_up     = head.circuit_up;
    assign res.circuit_down   = head.circuit_down;
    assign res.adjacency_init = head.adjacency_init;
    assign res.adj_address    = head.adj_address;
    assign res.adj_type       = head.adj_type;
    assign res.adj_hello      = head.adj_hello;
    assign res.last           = head.last;

endmodule

// ----- src/rifsm_checker.sv -----
// ----------------------------------------------------------------------------
// rifsm_checker
// Port-level checks of the routing init sublayer FSM unit, bound to the top.
// ----------------------------------------------------------------------------
`include "routing_init_sublayer_fsm_unit_assert.svh"

module rifsm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  out_new_state,
    input logic        out_start_line,
    input logic [15:0] out_adj_address,
    input logic        out_last
);

    // a stalled result holds
    `RIFSM_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_new_state) && $stable(out_start_line) && $stable(out_adj_address) && $stable(out_last), "result changed while stalled")

    // an accepted item shows a result on the next cycle
    `RIFSM_ASSERT(a_accept_res, clk, rst_n, in_valid && in_ready |=> out_valid, "accepted item gave no result")

    // the second result of a pair is ready straight after the first
    `RIFSM_ASSERT(a_pair_follow, clk, rst_n, out_valid && out_ready && !out_last |=> out_valid, "second result missing")

    // a non-last result is the operator off step: off or halt
    `RIFSM_ASSERT(a_first_off, clk, rst_n, out_valid && !out_last |-> out_new_state == rifsm_pkg::ST_OFF || out_new_state == rifsm_pkg::ST_HALT, "first of pair not off or halt")

    // nothing is offered straight out of reset
    `RIFSM_ASSERT_NORST(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind routing_init_sublayer_fsm_unit rifsm_checker u_rifsm_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (evt.valid),
    .in_ready        (evt.ready),
    .out_valid       (res.valid),
    .out_ready       (res.ready),
    .out_new_state   (res.new_state),
    .out_start_line  (res.start_line),
    .out_adj_address (res.adj_address),
    .out_last        (res.last)
);

// ----- tb/routing_init_sublayer_fsm_unit_tb.sv -----
// ----------------------------------------------------------------------------
// routing_init_sublayer_fsm_unit_tb
// Self-checking bench for the routing init sublayer FSM. A behavioural copy of
// the circuit state machine predicts the results of every item the block
// takes. Those results are checked in order, field by field. Each phase has
// its own register setting. Both channels idle in random bursts, except in the last phase.
// ----------------------------------------------------------------------------
module routing_init_sublayer_fsm_unit_tb;

    localparam int HALF_PERIOD       = 2;
    localparam int RESET_CYCLES      = 12;
    localparam int NO_PROGRESS_LIMIT = 2000;

    // operation codes the block does not know: one bare result, no change
    localparam logic [3:0] OP_UNKNOWN_LO = 4'd12;
    localparam logic [3:0] OP_UNKNOWN_HI = 4'd15;

    // level codes outside 1 and 2: no area check at all
    localparam logic [1:0] LEVEL_UNSET = 2'd0;
    localparam logic [1:0] LEVEL_BOTH  = 2'd3;

    // short action names so the tables stay readable
    localparam logic [2:0] A_NO = rifsm_pkg::ACT_NONE;
    localparam logic [2:0] A_RI = rifsm_pkg::ACT_REINIT;
    localparam logic [2:0] A_SP = rifsm_pkg::ACT_STOP;
    localparam logic [2:0] A_IN = rifsm_pkg::ACT_INIT;
    localparam logic [2:0] A_VF = rifsm_pkg::ACT_VERIFY;

    // next state per event (row) and current state (column)
    localparam logic [2:0] NEXT_STATE [12][8] = '{
        '{3'd1, 3'd1, 3'd2, 3'd4, 3'd2, 3'd2, 3'd6, 3'd7},  // init, verification asked
        '{3'd1, 3'd1, 3'd2, 3'd4, 3'd2, 3'd2, 3'd6, 3'd7},  // init, no verification
        '{3'd1, 3'd1, 3'd2, 3'd2, 3'd5, 3'd2, 3'd6, 3'd7},  // verify message
        '{3'd0, 3'd1, 3'd2, 3'd2, 3'd2, 3'd5, 3'd6, 3'd7},  // recall timeout
        '{3'd1, 3'd1, 3'd3, 3'd2, 3'd2, 3'd2, 3'd6, 3'd7},  // start complete
        '{3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd6, 3'd7},  // start error
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd1, 3'd2},  // operator on
        '{3'd6, 3'd6, 3'd7, 3'd7, 3'd7, 3'd7, 3'd6, 3'd7},  // operator off
        '{3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd6, 3'd7},  // invalid message
        '{3'd1, 3'd1, 3'd2, 3'd3, 3'd4, 3'd2, 3'd6, 3'd7},  // reject done
        '{3'd0, 3'd2, 3'd2, 3'd3, 3'd4, 3'd5, 3'd7, 3'd7},  // circuit down done
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd6, 3'd7}   // circuit up done
    };

    // action per event and current state, same layout
    localparam logic [2:0] NEXT_ACTION [12][8] = '{
        '{A_NO, A_NO, A_NO, A_VF, A_RI, A_RI, A_NO, A_NO},
        '{A_NO, A_NO, A_NO, A_NO, A_RI, A_RI, A_NO, A_NO},
        '{A_NO, A_NO, A_NO, A_RI, A_NO, A_RI, A_NO, A_NO},
        '{A_NO, A_NO, A_RI, A_RI, A_RI, A_NO, A_NO, A_NO},
        '{A_NO, A_NO, A_IN, A_RI, A_RI, A_RI, A_NO, A_NO},
        '{A_NO, A_NO, A_RI, A_RI, A_RI, A_RI, A_NO, A_NO},
        '{A_NO, A_NO, A_NO, A_NO, A_NO, A_NO, A_NO, A_RI},
        '{A_SP, A_NO, A_SP, A_SP, A_SP, A_SP, A_NO, A_NO},
        '{A_NO, A_NO, A_NO, A_RI, A_RI, A_RI, A_NO, A_NO},
        '{A_NO, A_NO, A_NO, A_NO, A_NO, A_RI, A_NO, A_NO},
        '{A_NO, A_RI, A_NO, A_NO, A_NO, A_NO, A_NO, A_NO},
        '{A_NO, A_NO, A_NO, A_NO, A_NO, A_NO, A_NO, A_NO}
    };

    // register writes go out in index order
    localparam logic [1:0] CFG_ORDER [4] = '{
        rifsm_pkg::CFG_OWN_AREA, rifsm_pkg::CFG_OWN_LEVEL,
        rifsm_pkg::CFG_MAX_NODE, rifsm_pkg::CFG_RECALL_TICKS
    };

    // ------------------------------------------------------------------------
    // Circuit state tracker: own copy of the registers, the circuit state and
    // the recall timer; turns each taken item into the results it must give.
    // ------------------------------------------------------------------------
    class circuit_state_tracker;
        logic [5:0]       own_area;
        logic [1:0]       own_level;
        logic [9:0]       max_node;
        logic [15:0]      recall_ticks;
        logic [2:0]       circuit_state;
        logic             recall_active;
        logic [15:0]      recall_count;
        logic [15:0]      adjacent_address;
        rifsm_pkg::res_t  awaited_results [$];
        int               errors;

        function new();
            own_area         = 6'd1;
            own_level        = rifsm_pkg::LEVEL_2;
            max_node         = 10'd1023;
            recall_ticks     = 16'd10;
            circuit_state    = rifsm_pkg::ST_OFF;
            recall_active    = 1'b0;
            recall_count     = '0;
            adjacent_address = '0;
            errors           = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [15:0] val);
            case (idx)
                rifsm_pkg::CFG_OWN_AREA:     own_area     = val[5:0];
                rifsm_pkg::CFG_OWN_LEVEL:    own_level    = val[1:0];
                rifsm_pkg::CFG_MAX_NODE:     max_node     = val[9:0];
                rifsm_pkg::CFG_RECALL_TICKS: recall_ticks = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        // one table step; flags are ORed into r
        function void take_event(logic [3:0] ev, inout rifsm_pkg::res_t r);
            logic [2:0] ns;
            logic [2:0] act;
            ns  = NEXT_STATE[ev][circuit_state];
            act = NEXT_ACTION[ev][circuit_state];
            if (ns != circuit_state)
            begin
                if (ns == rifsm_pkg::ST_COMPLETE)
                    r.circuit_up = 1'b1;
                else if (ns == rifsm_pkg::ST_REJECTED || ns == rifsm_pkg::ST_OFF)
                    r.circuit_down = 1'b1;
            end
            circuit_state = ns;
            case (act)
                rifsm_pkg::ACT_REINIT:
                    // skipped while the recall timer is still running
                    if (!recall_active)
                    begin
                        r.start_line  = 1'b1;
                        recall_active = 1'b1;
                        recall_count  = recall_ticks;
                    end
                rifsm_pkg::ACT_STOP:   r.stop_line   = 1'b1;
                rifsm_pkg::ACT_INIT:   r.send_init   = 1'b1;
                rifsm_pkg::ACT_VERIFY: r.send_verify = 1'b1;
                default: ;
            endcase
        endfunction

        function bit init_acceptable(rifsm_pkg::item_t it);
            if (it.src_node > max_node)
                return 1'b0;
            if (own_level == rifsm_pkg::LEVEL_1 && it.src_area != own_area)
                return 1'b0;
            if (own_level == rifsm_pkg::LEVEL_2 && it.node_type == rifsm_pkg::NODE_TYPE_L1
                && it.src_area != own_area)
                return 1'b0;
            return it.version_ok;
        endfunction

        function void note_item(rifsm_pkg::item_t it);
            rifsm_pkg::res_t r;
            r = '0;
            case (it.operation)
                rifsm_pkg::OP_TICK:
                    if (recall_active)
                    begin
                        if (recall_count <= 16'd1)
                        begin
                            recall_count  = '0;
                            recall_active = 1'b0;
                            // expiry in run state is silent
                            if (circuit_state != rifsm_pkg::ST_RUN)
                                take_event(rifsm_pkg::EV_TIMEOUT, r);
                        end
                        else
                            recall_count = recall_count - 16'd1;
                    end
                rifsm_pkg::OP_INIT_MSG:
                    if (init_acceptable(it))
                    begin
                        adjacent_address = {it.src_area, it.src_node};
                        take_event(it.verify_requested ? rifsm_pkg::EV_INIT_VRFY
                                                       : rifsm_pkg::EV_INIT_NOVRFY, r);
                        r.adjacency_init = 1'b1;
                        r.adj_address    = adjacent_address;
                        r.adj_type       = it.node_type;
                        r.adj_hello      = it.hello_timer;
                    end
                    else
                        take_event(rifsm_pkg::EV_INVALID, r);
                rifsm_pkg::OP_VERIFY_MSG:  take_event(rifsm_pkg::EV_VERIFY, r);
                rifsm_pkg::OP_START_DONE:  take_event(rifsm_pkg::EV_START_DONE, r);
                rifsm_pkg::OP_START_ERR:   take_event(rifsm_pkg::EV_START_ERR, r);
                rifsm_pkg::OP_OPER_ON:     take_event(rifsm_pkg::EV_OPER_ON, r);
                rifsm_pkg::OP_OPER_OFF:    take_event(rifsm_pkg::EV_OPER_OFF, r);
                rifsm_pkg::OP_INVALID:     take_event(rifsm_pkg::EV_INVALID, r);
                rifsm_pkg::OP_REJECT_DONE: take_event(rifsm_pkg::EV_REJECT_DONE, r);
                rifsm_pkg::OP_DOWN_DONE:   take_event(rifsm_pkg::EV_DOWN_DONE, r);
                rifsm_pkg::OP_UP_DONE:     take_event(rifsm_pkg::EV_UP_DONE, r);
                rifsm_pkg::OP_LINE_DOWN:
                begin
                    // operator off first, not last; operator on follows
                    take_event(rifsm_pkg::EV_OPER_OFF, r);
                    r.new_state = circuit_state;
                    r.last      = 1'b0;
                    awaited_results.push_back(r);
                    r = '0;
                    take_event(rifsm_pkg::EV_OPER_ON, r);
                end
                default: ;
            endcase
            r.new_state = circuit_state;
            r.last      = 1'b1;
            awaited_results.push_back(r);
        endfunction

        task report(string what);
            errors++;
            $display("mismatch at %0t: %s", $realtime, what);
        endtask

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("%s got %h want %h", name, got, want));
        endtask

        task check_result(rifsm_pkg::res_t got);
            rifsm_pkg::res_t want;
            if (awaited_results.size() == 0)
            begin
                report($sformatf("result with nothing awaited: %h", got));
                return;
            end
            want = awaited_results.pop_front();
            compare_field("new_state", 16'(got.new_state), 16'(want.new_state));
            compare_field("start_line", 16'(got.start_line), 16'(want.start_line));
            compare_field("stop_line", 16'(got.stop_line), 16'(want.stop_line));
            compare_field("send_init", 16'(got.send_init), 16'(want.send_init));
            compare_field("send_verify", 16'(got.send_verify), 16'(want.send_verify));
            compare_field("circuit_up", 16'(got.circuit_up), 16'(want.circuit_up));
            compare_field("circuit_down", 16'(got.circuit_down), 16'(want.circuit_down));
            compare_field("adjacency_init", 16'(got.adjacency_init),
                          16'(want.adjacency_init));
            compare_field("adj_address", got.adj_address, want.adj_address);
            compare_field("adj_type", 16'(got.adj_type), 16'(want.adj_type));
            compare_field("adj_hello", got.adj_hello, want.adj_hello);
            compare_field("last", 16'(got.last), 16'(want.last));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    rifsm_in_if  evt_ch ();
    rifsm_out_if res_ch ();

    circuit_state_tracker sb;
    bit              in_idle_en;
    bit              out_idle_en;
    int              res_stall;
    int              no_progress;
    rifsm_pkg::res_t seen_res;

    always #HALF_PERIOD clk = ~clk;

    routing_init_sublayer_fsm_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .evt       (evt_ch),
        .res       (res_ch)
    );

    // ------------------------------------------------------------------------
    // Item driving
    // ------------------------------------------------------------------------

    // Present one item and hold it until the block takes it. Called at a
    // rising edge; returns at the edge of acceptance, after the tracker has
    // seen the item, so the next item can be picked from the new state.
    task automatic drive_item(rifsm_pkg::item_t it);
        evt_ch.valid            <= 1'b1;
        evt_ch.operation        <= it.operation;
        evt_ch.src_area         <= it.src_area;
        evt_ch.src_node         <= it.src_node;
        evt_ch.node_type        <= it.node_type;
        evt_ch.verify_requested <= it.verify_requested;
        evt_ch.version_ok       <= it.version_ok;
        evt_ch.hello_timer      <= it.hello_timer;
        @(posedge clk);
        while (!evt_ch.ready)
            @(posedge clk);
        sb.note_item(it);
    endtask

    task automatic drive_gap(int cycles);
        evt_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Drop valid and let every awaited result drain; the user writes its registers only
    // while idle (the block does not enforce it), so this is run before each register phase.
    task automatic settle();
        evt_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // All four registers in one burst; write enable stays high throughout.
    task automatic write_config(logic [5:0] area, logic [1:0] level,
                                logic [9:0] top_node, logic [15:0] ticks);
        logic [15:0] vals [4];
        vals[0] = 16'(area);
        vals[1] = 16'(level);
        vals[2] = 16'(top_node);
        vals[3] = ticks;
        cfg_we <= 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            cfg_index <= CFG_ORDER[i];
            cfg_data  <= vals[i];
            sb.set_register(CFG_ORDER[i], vals[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic rifsm_pkg::item_t mk(logic [3:0] op, logic [5:0] area,
                                            logic [9:0] node, logic [1:0] ntype,
                                            logic vreq, logic vok, logic [15:0] hello);
        return '{op, area, node, ntype, vreq, vok, hello};
    endfunction

    // item with every field but the operation at zero
    function automatic rifsm_pkg::item_t mk_bare(logic [3:0] op);
        return mk(op, '0, '0, '0, 1'b0, 1'b0, '0);
    endfunction

    // Random item. A quarter is pure noise over all sixteen codes, a fifth
    // are ticks to run the recall timer down, the rest move the circuit on
    // from its present state, so that bring-up reaches complete and run.
    function automatic rifsm_pkg::item_t random_event();
        rifsm_pkg::item_t it;
        int               pick;
        it.operation        = 4'($urandom_range(0, 15));
        it.src_area         = 6'($urandom);
        it.src_node         = 10'($urandom);
        it.node_type        = 2'($urandom);
        it.verify_requested = 1'($urandom);
        it.version_ok       = 1'($urandom);
        it.hello_timer      = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 25)
            return it;
        if (pick < 45)
        begin
            it.operation = rifsm_pkg::OP_TICK;
            return it;
        end
        case (sb.circuit_state)
            rifsm_pkg::ST_OFF, rifsm_pkg::ST_HALT: it.operation = rifsm_pkg::OP_OPER_ON;
            rifsm_pkg::ST_REJECTED:  it.operation = rifsm_pkg::OP_DOWN_DONE;
            rifsm_pkg::ST_DL_START:
                it.operation = ($urandom_range(0, 5) == 0) ? rifsm_pkg::OP_START_ERR
                                                           : rifsm_pkg::OP_START_DONE;
            rifsm_pkg::ST_INIT:      it.operation = rifsm_pkg::OP_INIT_MSG;
            rifsm_pkg::ST_VERIFY:    it.operation = rifsm_pkg::OP_VERIFY_MSG;
            rifsm_pkg::ST_COMPLETE:  it.operation = rifsm_pkg::OP_UP_DONE;
            default:
                // in run: knock the circuit down one way or another
                case ($urandom_range(0, 3))
                    0:       it.operation = rifsm_pkg::OP_LINE_DOWN;
                    1:       it.operation = rifsm_pkg::OP_OPER_OFF;
                    2:       it.operation = rifsm_pkg::OP_START_ERR;
                    default: it.operation = rifsm_pkg::OP_INVALID;
                endcase
        endcase
        // most init messages are made acceptable, the rest stay random
        if (it.operation == rifsm_pkg::OP_INIT_MSG && $urandom_range(0, 7) != 0)
        begin
            it.src_area   = sb.own_area;
            it.src_node   = 10'($urandom_range(0, sb.max_node));
            it.version_ok = 1'b1;
        end
        return it;
    endfunction

    task automatic run_phase(int items, bit idling);
        for (int n = 0; n < items; n++)
        begin
            // idling switches on and off in stretches of 40 items
            if (n % 40 == 0)
            begin
                in_idle_en  = idling && ($urandom_range(0, 3) != 0);
                out_idle_en = idling && ($urandom_range(0, 3) != 0);
            end
            if (in_idle_en && $urandom_range(0, 7) == 0)
                drive_gap($urandom_range(1, 19));
            drive_item(random_event());
        end
        settle();
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stall bursts on ready, checking on every take
    // ------------------------------------------------------------------------
    initial
    begin
        res_stall = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_stall > 0)
            begin
                res_stall--;
                res_ch.ready <= 1'b0;
            end
            else if (out_idle_en && $urandom_range(0, 9) == 0)
            begin
                res_stall = $urandom_range(1, 19) - 1;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            seen_res = '{res_ch.new_state, res_ch.start_line, res_ch.stop_line,
                         res_ch.send_init, res_ch.send_verify, res_ch.circuit_up,
                         res_ch.circuit_down, res_ch.adjacency_init, res_ch.adj_address,
                         res_ch.adj_type, res_ch.adj_hello, res_ch.last};
            sb.check_result(seen_res);
        end
    end

    // Watchdog: too long with nothing taken on either channel ends the run.
    initial
    begin
        no_progress = 0;
        forever
        begin
            @(posedge clk);
            if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready))
                no_progress = 0;
            else
                no_progress++;
            if (no_progress >= NO_PROGRESS_LIMIT)
            begin
                $display("** routing_init_sublayer_fsm_unit: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        sb          = new();
        in_idle_en  = 1'b0;
        out_idle_en = 1'b0;
        rst_n                   <= 1'b0;
        cfg_we                  <= 1'b0;
        cfg_index               <= rifsm_pkg::CFG_OWN_AREA;
        cfg_data                <= '0;
        evt_ch.valid            <= 1'b0;
        evt_ch.operation        <= rifsm_pkg::OP_TICK;
        evt_ch.src_area         <= '0;
        evt_ch.src_node         <= '0;
        evt_ch.node_type        <= '0;
        evt_ch.verify_requested <= 1'b0;
        evt_ch.version_ok       <= 1'b0;
        evt_ch.hello_timer      <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed walk with reset register values; recall time 10, so the
        // timer started early on is still running for the skipped reinits.
        out_idle_en = 1'b1;
        drive_item(mk(OP_UNKNOWN_HI, 6'h3f, 10'h3ff, 2'd3, 1'b1, 1'b1, 16'hffff));
        drive_item(mk_bare(rifsm_pkg::OP_TICK));          // timer idle: no change
        drive_item(mk_bare(rifsm_pkg::OP_OPER_ON));       // off -> rejected
        drive_item(mk_bare(rifsm_pkg::OP_DOWN_DONE));     // -> dl start, timer on
        drive_item(mk_bare(rifsm_pkg::OP_START_ERR));     // reinit skipped
        drive_item(mk_bare(rifsm_pkg::OP_START_DONE));    // -> init, send init
        drive_item(mk(rifsm_pkg::OP_INIT_MSG, 6'd1, 10'd5, 2'd0, 1'b1, 1'b0,
                      16'h1234));                         // bad version
        drive_item(mk_bare(rifsm_pkg::OP_START_DONE));
        drive_item(mk(rifsm_pkg::OP_INIT_MSG, 6'd1, 10'h3ff, 2'd2, 1'b1, 1'b1,
                      16'hffff));                         // -> verify
        drive_item(mk_bare(rifsm_pkg::OP_VERIFY_MSG));    // -> complete, up
        drive_item(mk_bare(rifsm_pkg::OP_UP_DONE));       // -> run
        drive_item(mk_bare(rifsm_pkg::OP_INVALID));       // run -> rejected
        drive_item(mk_bare(rifsm_pkg::OP_REJECT_DONE));
        drive_item(mk_bare(rifsm_pkg::OP_OPER_OFF));      // rejected -> off
        drive_item(mk_bare(rifsm_pkg::OP_OPER_ON));
        drive_item(mk_bare(rifsm_pkg::OP_DOWN_DONE));
        drive_item(mk_bare(rifsm_pkg::OP_START_DONE));
        drive_item(mk(rifsm_pkg::OP_INIT_MSG, 6'd1, 10'd0, 2'd0, 1'b0, 1'b1,
                      16'h0000));                         // no verify
        drive_item(mk_bare(rifsm_pkg::OP_OPER_OFF));      // verify -> halt, stop
        drive_item(mk_bare(rifsm_pkg::OP_OPER_ON));       // halt -> dl start
        drive_item(mk_bare(rifsm_pkg::OP_LINE_DOWN));     // two results
        drive_item(mk(rifsm_pkg::OP_INIT_MSG, 6'd0, 10'd7, 2'd2, 1'b1, 1'b1,
                      16'h00ff));                         // wrong area
        drive_item(mk_bare(OP_UNKNOWN_LO));
        settle();

        // Register phases: extremes first, then random settings. Zero recall
        // time expires on the first tick; the longest one never expires.
        write_config(6'd63, rifsm_pkg::LEVEL_1, 10'd1023, 16'd1);
        run_phase(270, 1'b1);
        write_config(6'd1, rifsm_pkg::LEVEL_2, 10'd1, 16'd0);
        run_phase(270, 1'b1);
        write_config(6'($urandom_range(1, 63)), LEVEL_UNSET,
                     10'($urandom_range(1, 1023)), 16'd3);
        run_phase(270, 1'b1);
        write_config(6'($urandom_range(1, 63)), LEVEL_BOTH, 10'd1, 16'd2);
        run_phase(270, 1'b1);
        write_config(6'($urandom_range(1, 63)), rifsm_pkg::LEVEL_2,
                     10'($urandom_range(1, 1023)), 16'd65535);
        run_phase(270, 1'b1);
        write_config(6'($urandom_range(1, 63)), rifsm_pkg::LEVEL_1,
                     10'($urandom_range(1, 1023)), 16'($urandom_range(1, 8)));
        run_phase(270, 1'b1);
        // last stretch runs flat out on both sides
        write_config(6'($urandom_range(1, 63)), rifsm_pkg::LEVEL_2,
                     10'($urandom_range(1, 1023)), 16'($urandom_range(2, 5)));
        run_phase(270, 1'b0);

        if (sb.errors == 0)
            $display("** routing_init_sublayer_fsm_unit: PASSED **");
        else
            $display("** routing_init_sublayer_fsm_unit: FAILED **");
        $finish;
    end

endmodule

// ----- routing_init_sublayer_fsm_unit.f -----
+incdir+src
src/rifsm_pkg.sv
src/rifsm_in_if.sv
src/rifsm_out_if.sv
src/rifsm_eval.sv
src/rifsm_res_fifo.sv
src/routing_init_sublayer_fsm_unit.sv
src/rifsm_checker.sv
tb/routing_init_sublayer_fsm_unit_tb.sv
